// File: hdl/mean_variance_stddev_assert.svh
// Assertion macros for the statistics block.
`ifndef MEAN_VARIANCE_STDDEV_ASSERT_SVH
`define MEAN_VARIANCE_STDDEV_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define MVS_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mvs check failed");
// checked through reset as well
`define MVS_CHECK_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mvs reset check failed");
`else
`define MVS_CHECK(label, prop)
`define MVS_CHECK_RST(label, prop)
`endif

`endif

// File: hdl/mvs_pkg.sv
package mvs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MEAN_W   = 24;
  localparam int VAR_W    = 39;
  localparam int STD_W    = 24;
  localparam int CNT_W    = 11;

  typedef logic [2:0] op_t;

  localparam op_t OP_MUL_NS   = 3'd0;  // n * sum of squares
  localparam op_t OP_MUL_SS   = 3'd1;  // |sum| * |sum|
  localparam op_t OP_MUL_NN   = 3'd2;  // n * n
  localparam op_t OP_DIV_MEAN = 3'd3;
  localparam op_t OP_DIV_VAR  = 3'd4;
  localparam op_t OP_SQRT     = 3'd5;

  typedef struct packed {
    logic capture;
    logic accum;
    logic load;
    logic step;
    logic store;
    logic emit;
    op_t  op;
  } cmd_t;

endpackage

// File: hdl/mean_variance_stddev.sv
// Channel   Handshake          Fields
// -------   ----------------   ---------------------------------------------------
// in        start / busy       sample, last
// out       done (1 cycle)     mean_q, variance_q, std_dev_q, sample_count, overflow
//
// An item that is not last is taken every cycle; busy stays low.
// After the last item, busy rises; done follows once the shift-add multiplier,
// the restoring divider and the square root have run in turn.
// Synchronous reset clears the accumulators and the sequencer.
// Results hold until the next done (high for one cycle); the receiver cannot stall.
`include "mean_variance_stddev_assert.svh"

module mean_variance_stddev #(
  parameter int MAX_COUNT = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mvs_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                 last,
  output logic                                 done,
  output logic signed [mvs_pkg::MEAN_W-1:0]    mean_q,
  output logic        [mvs_pkg::VAR_W-1:0]     variance_q,
  output logic        [mvs_pkg::STD_W-1:0]     std_dev_q,
  output logic        [mvs_pkg::CNT_W-1:0]     sample_count,
  output logic                                 overflow
);

  localparam int LG         = $clog2(MAX_COUNT);
  localparam int MUL_STEPS  = 16 + LG;
  localparam int DIV_STEPS  = 31 + 2 * LG + 2 * FRAC_BITS;
  localparam int SQRT_STEPS = 16 + FRAC_BITS;

  mvs_pkg::cmd_t cmd;

  mvs_ctrl #(
    .MUL_STEPS (MUL_STEPS),
    .DIV_STEPS (DIV_STEPS),
    .SQRT_STEPS(SQRT_STEPS)
  ) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .last (last),
    .busy (busy),
    .done (done),
    .cmd  (cmd)
  );

  mvs_dp #(
    .MAX_COUNT(MAX_COUNT),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .sample      (sample),
    .cmd         (cmd),
    .mean_q      (mean_q),
    .variance_q  (variance_q),
    .std_dev_q   (std_dev_q),
    .sample_count(sample_count),
    .overflow    (overflow)
  );

  `MVS_CHECK(a_done_after_busy, done |-> $past(busy))
  `MVS_CHECK(a_last_sets_busy, (start && !busy && last) |=> busy)
  `MVS_CHECK(a_done_single, done |=> !done)
  `MVS_CHECK_RST(a_reset_idle, rst |=> (!busy && !done))

endmodule

// File: hdl/mvs_ctrl.sv
module mvs_ctrl #(
  parameter int MUL_STEPS  = 26,
  parameter int DIV_STEPS  = 67,
  parameter int SQRT_STEPS = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           last,
  output logic           busy,
  output logic           done,
  output mvs_pkg::cmd_t  cmd
);

  localparam int CNTW = $clog2(DIV_STEPS + 2);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LAST     = 4'd1;
  localparam logic [3:0] ST_MUL_NS   = 4'd2;
  localparam logic [3:0] ST_MUL_SS   = 4'd3;
  localparam logic [3:0] ST_MUL_NN   = 4'd4;
  localparam logic [3:0] ST_DIV_MEAN = 4'd5;
  localparam logic [3:0] ST_DIV_VAR  = 4'd6;
  localparam logic [3:0] ST_SQRT     = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;

  logic [3:0]      state, state_next, nxt;
  logic [CNTW-1:0] cnt, cnt_next, limit;
  logic            pend;
  logic            accept;
  logic            in_op;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.accum   = pend;
    state_next  = state;
    cnt_next    = cnt;
    limit       = '0;
    nxt         = ST_IDLE;
    in_op       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && last) state_next = ST_LAST;
      end
      ST_LAST: begin
        state_next = ST_MUL_NS;
        cnt_next   = '0;
      end
      ST_MUL_NS: begin
        cmd.op = mvs_pkg::OP_MUL_NS;
        limit  = CNTW'(MUL_STEPS);
        nxt    = ST_MUL_SS;
        in_op  = 1'b1;
      end
      ST_MUL_SS: begin
        cmd.op = mvs_pkg::OP_MUL_SS;
        limit  = CNTW'(MUL_STEPS);
        nxt    = ST_MUL_NN;
        in_op  = 1'b1;
      end
      ST_MUL_NN: begin
        cmd.op = mvs_pkg::OP_MUL_NN;
        limit  = CNTW'(MUL_STEPS);
        nxt    = ST_DIV_MEAN;
        in_op  = 1'b1;
      end
      ST_DIV_MEAN: begin
        cmd.op = mvs_pkg::OP_DIV_MEAN;
        limit  = CNTW'(DIV_STEPS);
        nxt    = ST_DIV_VAR;
        in_op  = 1'b1;
      end
      ST_DIV_VAR: begin
        cmd.op = mvs_pkg::OP_DIV_VAR;
        limit  = CNTW'(DIV_STEPS);
        nxt    = ST_SQRT;
        in_op  = 1'b1;
      end
      ST_SQRT: begin
        cmd.op = mvs_pkg::OP_SQRT;
        limit  = CNTW'(SQRT_STEPS);
        nxt    = ST_EMIT;
        in_op  = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // load, then limit steps, then store
    if (in_op) begin
      if (cnt == '0) begin
        cmd.load = 1'b1;
      end else if (cnt <= limit) begin
        cmd.step = 1'b1;
      end else begin
        cmd.store  = 1'b1;
        state_next = nxt;
      end
      cnt_next = cmd.store ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= accept;
      done  <= cmd.emit;
    end
  end

endmodule

// File: hdl/mvs_dp.sv
module mvs_dp #(
  parameter int MAX_COUNT = 1024,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [mvs_pkg::SAMPLE_W-1:0]  sample,
  input  mvs_pkg::cmd_t                        cmd,
  output logic signed [mvs_pkg::MEAN_W-1:0]    mean_q,
  output logic        [mvs_pkg::VAR_W-1:0]     variance_q,
  output logic        [mvs_pkg::STD_W-1:0]     std_dev_q,
  output logic        [mvs_pkg::CNT_W-1:0]     sample_count,
  output logic                                 overflow
);

  localparam int LG   = $clog2(MAX_COUNT);
  localparam int CW   = $clog2(MAX_COUNT + 1);
  localparam int SW   = 16 + LG;
  localparam int QW   = 31 + LG;
  localparam int PW   = 31 + 2 * LG;
  localparam int N2W  = 2 * CW;
  localparam int DVW  = PW + 2 * FRAC_BITS;
  localparam int MQW  = SW + FRAC_BITS;
  localparam int VW2  = 31 + 2 * FRAC_BITS;
  localparam int EVW  = VW2 + 1;
  localparam int RW   = EVW / 2;
  localparam int MEXT = (MQW > mvs_pkg::MEAN_W) ? MQW : mvs_pkg::MEAN_W;
  localparam int VEXT = (VW2 > mvs_pkg::VAR_W) ? VW2 : mvs_pkg::VAR_W;
  localparam int REXT = (RW > mvs_pkg::STD_W) ? RW : mvs_pkg::STD_W;
  localparam int CEXT = (CW > mvs_pkg::CNT_W) ? CW : mvs_pkg::CNT_W;

  logic signed [mvs_pkg::SAMPLE_W-1:0] x;
  logic signed [31:0]                  sq;
  logic signed [SW-1:0]                sum;
  logic        [SW-1:0]                sum_u, mag;
  logic        [QW-1:0]                sumsq;
  logic        [CW-1:0]                count;
  logic                                ovf;

  logic [PW-1:0]  prod, mc, d;
  logic [SW-1:0]  mr;
  logic [N2W-1:0] n2, rem, dvs;
  logic [DVW-1:0] dd;
  logic [N2W:0]   trial;
  logic [MQW-1:0] mean_mag;
  logic [VW2-1:0] var2, var_sh;
  logic [EVW-1:0] sv, root, sbit, rb;

  logic [MEXT-1:0] mext, mneg;
  logic [VEXT-1:0] vext;
  logic [REXT-1:0] rext;
  logic [CEXT-1:0] cext;

  assign sq     = x * x;
  assign sum_u  = sum;
  assign mag    = sum[SW-1] ? (SW'(0) - sum_u) : sum_u;
  assign trial  = {rem, dd[DVW-1]};
  assign rb     = root + sbit;
  assign mext   = MEXT'(mean_mag);
  assign mneg   = MEXT'(0) - mext;
  assign var_sh = var2 >> FRAC_BITS;
  assign vext   = VEXT'(var_sh);
  assign rext   = REXT'(root);
  assign cext   = CEXT'(count);

  // accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sumsq <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.emit) begin
      sum   <= '0;
      sumsq <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.accum) begin
      if (count < CW'(MAX_COUNT)) begin
        sum   <= sum + SW'(x);
        sumsq <= sumsq + QW'(sq[30:0]);
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) x <= sample;

    if (cmd.load) begin
      case (cmd.op)
        mvs_pkg::OP_MUL_NS: begin
          prod <= '0;
          mr   <= SW'(count);
          mc   <= PW'(sumsq);
        end
        mvs_pkg::OP_MUL_SS: begin
          prod <= '0;
          mr   <= mag;
          mc   <= PW'(mag);
        end
        mvs_pkg::OP_MUL_NN: begin
          prod <= '0;
          mr   <= SW'(count);
          mc   <= PW'(count);
        end
        mvs_pkg::OP_DIV_MEAN: begin
          rem <= '0;
          dd  <= DVW'(mag) << FRAC_BITS;
          dvs <= N2W'(count);
        end
        mvs_pkg::OP_DIV_VAR: begin
          rem <= '0;
          dd  <= DVW'(d) << (2 * FRAC_BITS);
          dvs <= n2;
        end
        mvs_pkg::OP_SQRT: begin
          sv   <= EVW'(var2);
          root <= '0;
          sbit <= EVW'(1) << (EVW - 2);
        end
        default: ;
      endcase
    end

    if (cmd.step) begin
      case (cmd.op)
        mvs_pkg::OP_MUL_NS, mvs_pkg::OP_MUL_SS, mvs_pkg::OP_MUL_NN: begin
          if (mr[0]) prod <= prod + mc;
          mr <= mr >> 1;
          mc <= mc << 1;
        end
        mvs_pkg::OP_DIV_MEAN, mvs_pkg::OP_DIV_VAR: begin
          if (trial >= {1'b0, dvs}) begin
            rem <= N2W'(trial - {1'b0, dvs});
            dd  <= {dd[DVW-2:0], 1'b1};
          end else begin
            rem <= trial[N2W-1:0];
            dd  <= {dd[DVW-2:0], 1'b0};
          end
        end
        mvs_pkg::OP_SQRT: begin
          if (sv >= rb) begin
            sv   <= sv - rb;
            root <= (root >> 1) + sbit;
          end else begin
            root <= root >> 1;
          end
          sbit <= sbit >> 2;
        end
        default: ;
      endcase
    end

    if (cmd.store) begin
      case (cmd.op)
        mvs_pkg::OP_MUL_NS:   d        <= prod;
        mvs_pkg::OP_MUL_SS:   d        <= d - prod;
        mvs_pkg::OP_MUL_NN:   n2       <= prod[N2W-1:0];
        mvs_pkg::OP_DIV_MEAN: mean_mag <= dd[MQW-1:0];
        mvs_pkg::OP_DIV_VAR:  var2     <= dd[VW2-1:0];
        default: ;
      endcase
    end

    if (cmd.emit) begin
      mean_q       <= $signed(sum[SW-1] ? mneg[mvs_pkg::MEAN_W-1:0]
                                        : mext[mvs_pkg::MEAN_W-1:0]);
      variance_q   <= vext[mvs_pkg::VAR_W-1:0];
      std_dev_q    <= rext[mvs_pkg::STD_W-1:0];
      sample_count <= cext[mvs_pkg::CNT_W-1:0];
      overflow     <= ovf;
    end
  end

endmodule

// File: test/mean_variance_stddev_tb.sv
module mean_variance_stddev_tb;

  localparam int SAMPLE_W     = mvs_pkg::SAMPLE_W;
  localparam int MEAN_W       = mvs_pkg::MEAN_W;
  localparam int VAR_W        = mvs_pkg::VAR_W;
  localparam int STD_W        = mvs_pkg::STD_W;
  localparam int CNT_W        = mvs_pkg::CNT_W;

  localparam int MAX_N        = 1024;
  localparam int FRAC         = 8;
  localparam int LIMIT        = 1000000;
  localparam int SETTLE       = 300;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MIN_SETS     = 30;

  typedef struct {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [STD_W-1:0]         std_dev;
    logic [CNT_W-1:0]         n;
    logic                     ovf;
  } stats_t;

  class dataset_stats;
    longint          sum;
    longint unsigned sumsq;
    int unsigned     n;
    bit              ovf;
    stats_t          expected_stats[$];
    int              errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      sum = 0;
      sumsq = 0;
      n = 0;
      ovf = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned b;
      root = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= root + b) begin
          v -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // accumulate one accepted item; on the last one, compute the dataset stats
    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic l);
      longint          x;
      longint unsigned nn, mag, mq, n2, d, q, r, v1, v2;
      stats_t          e;
      x = s;
      if (n < MAX_N) begin
        sum += x;
        sumsq += longint'(x * x);
        n++;
      end else begin
        ovf = 1;
      end
      if (!l) return;
      nn = n;
      mag = (sum < 0) ? longint'(-sum) : sum;
      mq = (mag << FRAC) / nn;
      e.mean = MEAN_W'((sum < 0) ? (64'd0 - mq) : mq);
      n2 = nn * nn;
      d = nn * sumsq - mag * mag;
      q = d / n2;
      r = d % n2;
      v1 = (q << FRAC) + (r << FRAC) / n2;
      v2 = (q << (2 * FRAC)) + (r << (2 * FRAC)) / n2;
      e.variance = VAR_W'(v1);
      e.std_dev = STD_W'(isqrt(v2));
      e.n = CNT_W'(n);
      e.ovf = ovf;
      expected_stats.push_back(e);
      clear();
    endfunction

    task check_result(stats_t got);
      stats_t e;
      if (expected_stats.size() == 0) begin
        report($sformatf("unexpected result mean=%0d count=%0d", got.mean, got.n));
        return;
      end
      e = expected_stats.pop_front();
      if (got.mean !== e.mean)
        report($sformatf("mean_q got %0d exp %0d", got.mean, e.mean));
      if (got.variance !== e.variance)
        report($sformatf("variance_q got %0d exp %0d", got.variance, e.variance));
      if (got.std_dev !== e.std_dev)
        report($sformatf("std_dev_q got %0d exp %0d", got.std_dev, e.std_dev));
      if (got.n !== e.n)
        report($sformatf("sample_count got %0d exp %0d", got.n, e.n));
      if (got.ovf !== e.ovf)
        report($sformatf("overflow got %0b exp %0b", got.ovf, e.ovf));
    endtask
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       done;
  logic signed [MEAN_W-1:0]   mean_q;
  logic [VAR_W-1:0]           variance_q;
  logic [STD_W-1:0]           std_dev_q;
  logic [CNT_W-1:0]           sample_count;
  logic                       overflow;

  dataset_stats stats = new();
  stats_t       got_stats;
  int           sent = 0;

  mean_variance_stddev #(
    .MAX_COUNT(MAX_N),
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sample(sample),
    .last(last),
    .done(done),
    .mean_q(mean_q),
    .variance_q(variance_q),
    .std_dev_q(std_dev_q),
    .sample_count(sample_count),
    .overflow(overflow)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got_stats.mean = mean_q;
        got_stats.variance = variance_q;
        got_stats.std_dev = std_dev_q;
        got_stats.n = sample_count;
        got_stats.ovf = overflow;
        stats.check_result(got_stats);
      end
      if (start && !busy) stats.take_sample(sample, last);
    end
  end

  task automatic send_item(logic signed [SAMPLE_W-1:0] s, logic l);
    @(negedge clk);
    start <= 1'b1;
    sample <= s;
    last <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic pause(int cycles);
    if (cycles == 0) return;
    @(negedge clk);
    start <= 1'b0;
    sample <= SAMPLE_W'($urandom);
    last <= 1'($urandom_range(0, 1));
    repeat (cycles - 1) @(negedge clk);
  endtask

  // hold off until every pending dataset result has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (stats.expected_stats.size() != 0) @(negedge clk);
  endtask

  function automatic int rand_gap(bit quiet);
    int p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 70) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_sample();
    logic signed [SAMPLE_W-1:0] t;
    t = SAMPLE_W'($urandom);
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(0, 200)) - 100;
      default: return t;
    endcase
  endfunction

  task automatic send_dataset(input int vals[$], input bit quiet);
    foreach (vals[i]) begin
      send_item(SAMPLE_W'(vals[i]), i == vals.size() - 1);
      pause(rand_gap(quiet));
    end
  endtask

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("mean_variance_stddev_tb: FAIL");
    $finish;
  end

  initial begin
    int  vals[$];
    int  len;
    bit  quiet;
    start = 1'b0;
    sample = '0;
    last = 1'b0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    vals = '{32767};
    send_dataset(vals, 1);
    vals = '{-32768};
    send_dataset(vals, 0);
    vals = '{0};
    send_dataset(vals, 1);
    vals = '{-32768, 32767};
    send_dataset(vals, 1);
    vals = '{-1, 0, 1};
    send_dataset(vals, 0);
    vals = '{-1, -1, 0};
    send_dataset(vals, 1);
    vals = '{5, 7, 8, 100, -2};
    send_dataset(vals, 0);
    vals = '{-32768, -32768, 32767, 32767, 1};
    send_dataset(vals, 1);
    drain();

    for (int ds = 0; sent < RANDOM_ITEMS || ds < MIN_SETS; ds++) begin
      vals.delete();
      quiet = ($urandom_range(0, 3) == 0);
      if (ds == 10) begin
        // full count at the most negative value, then items past the limit
        repeat (MAX_N) vals.push_back(-32768);
        len = 1 + $urandom_range(0, 3);
        repeat (len) vals.push_back(($urandom_range(0, 1) == 1) ? 32767 : -32768);
        drain();
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
        repeat (len) vals.push_back(rand_sample());
        if ($urandom_range(0, 15) == 0) drain();
      end
      send_dataset(vals, quiet);
    end

    @(negedge clk);
    start <= 1'b0;
    while (stats.expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (stats.errors == 0) begin
      $display("mean_variance_stddev_tb: PASS");
    end else begin
      $display("mean_variance_stddev_tb: FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+hdl
hdl/mvs_pkg.sv
hdl/mvs_ctrl.sv
hdl/mvs_dp.sv
hdl/mean_variance_stddev.sv
test/mean_variance_stddev_tb.sv
